>>> rtl/llg_jacobian_vector_product_unit_assert.svh
// assertion macros used by the checker of the jacobian-vector product unit
`ifndef LLG_JACOBIAN_VECTOR_PRODUCT_UNIT_ASSERT_SVH
`define LLG_JACOBIAN_VECTOR_PRODUCT_UNIT_ASSERT_SVH

// implication checked outside reset
`define LLGJV_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("llgjv assertion failed");

// implication with a fixed delay, checked outside reset
`define LLGJV_ASSERT_DLY(label, clk, rst, ante, n, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> ##n (cons)) \
    else $error("llgjv assertion failed");

// implication checked in every cycle, reset included
`define LLGJV_ASSERT_ALL(label, clk, ante, cons) \
  label: assert property (@(posedge clk) (ante) |-> (cons)) \
    else $error("llgjv assertion failed");

`endif

>>> rtl/llgjv_pkg.sv
package llgjv_pkg;

  localparam int WordW      = 32;
  localparam int FracM      = 29;
  localparam int CoeffShift = 23;
  localparam int RelaxShift = 37;
  localparam int ProdW      = 2 * WordW - FracM;
  localparam int DotW       = 37;
  localparam int PrecW      = 37;
  localparam int BrW        = 42;
  localparam int SplitW     = 21;
  localparam int TermW      = 52;
  localparam int SumW       = TermW + 2;
  localparam int OutW       = 48;
  localparam int EnW        = 3;
  localparam int Latency    = 7;

  localparam int EnDamping    = 0;
  localparam int EnPrecession = 1;
  localparam int EnRelaxation = 2;

  localparam logic [EnW-1:0] EnableReset = 3'd7;

  typedef enum logic [1:0] {
    RegDamping,
    RegPrecession,
    RegRelaxation,
    RegTermEnable
  } reg_index_t;

  typedef logic signed [WordW-1:0] word_t;
  typedef word_t [2:0] word3_t;

  typedef logic signed [DotW-1:0] dot_val_t;
  typedef logic signed [PrecW-1:0] prec_t;
  typedef prec_t [2:0] prec3_t;

  typedef logic signed [BrW-1:0] br_t;
  typedef br_t [2:0] br3_t;

  typedef logic signed [OutW-1:0] out_t;
  typedef out_t [2:0] out3_t;

  typedef struct packed {
    word3_t m;
    word3_t mp;
    word3_t h;
    word3_t hp;
  } node_t;

  typedef struct packed {
    node_t    node;
    dot_val_t mh;
    dot_val_t mphh;
    dot_val_t mm;
    dot_val_t mmp;
    dot_val_t one_mm;
    prec3_t   prec;
  } dot_t;

  typedef struct packed {
    br3_t damp;
    br3_t prec;
    br3_t relax;
  } bracket_t;

  typedef struct packed {
    word_t          damping;
    word_t          precession;
    word_t          relaxation;
    logic [EnW-1:0] enable;
  } coeff_t;

endpackage

>>> rtl/llg_jacobian_vector_product_unit.sv
// Per-node jacobian-vector product for the llg equation, built as a seven stage pipeline:
// one node is taken on every clock at which start is high (busy stays low), and its
// contribution appears on contrib_x/y/z with done high for exactly one cycle at the end
// of the pipeline, in the order the nodes went in. Throughput is one node per cycle; the
// stages hold two rounds of 32-bit products (dot products, then brackets), the coefficient
// product split into two partial products, and the final add and saturation. The receiver
// cannot stall: every result must be taken in the cycle done is high. Coefficient and
// enable registers are written through cfg_write/cfg_index/cfg_data and act on nodes in
// flight, so they are to be written only when no transfer is pending.
module llg_jacobian_vector_product_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [31:0] mag_x,
  input  logic [31:0] mag_y,
  input  logic [31:0] mag_z,
  input  logic [31:0] dmag_x,
  input  logic [31:0] dmag_y,
  input  logic [31:0] dmag_z,
  input  logic [31:0] field_x,
  input  logic [31:0] field_y,
  input  logic [31:0] field_z,
  input  logic [31:0] dfield_x,
  input  logic [31:0] dfield_y,
  input  logic [31:0] dfield_z,
  input  logic        cfg_write,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data,
  output logic        done,
  output logic [47:0] contrib_x,
  output logic [47:0] contrib_y,
  output logic [47:0] contrib_z,
  output logic        saturated
);

  localparam int EnW = llgjv_pkg::EnW;

  logic signed [31:0]   damping_coeff;
  logic signed [31:0]   precession_coeff;
  logic signed [31:0]   relaxation_coeff;
  logic [EnW-1:0]       term_enable;

  llgjv_pkg::node_t     node;
  llgjv_pkg::coeff_t    coeff;
  llgjv_pkg::dot_t      dot;
  llgjv_pkg::bracket_t  br;
  llgjv_pkg::out3_t     contrib;
  logic                 accept;
  logic                 dot_valid;
  logic                 br_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      damping_coeff    <= '0;
      precession_coeff <= '0;
      relaxation_coeff <= '0;
      term_enable      <= llgjv_pkg::EnableReset;
    end else if (cfg_write) begin
      unique case (llgjv_pkg::reg_index_t'(cfg_index))
        llgjv_pkg::RegDamping:    damping_coeff    <= cfg_data;
        llgjv_pkg::RegPrecession: precession_coeff <= cfg_data;
        llgjv_pkg::RegRelaxation: relaxation_coeff <= cfg_data;
        llgjv_pkg::RegTermEnable: term_enable      <= cfg_data[EnW-1:0];
        default: ;
      endcase
    end
  end

  assign busy   = 1'b0;
  assign accept = start && !busy;

  always_comb begin
    node.m  = {mag_z, mag_y, mag_x};
    node.mp = {dmag_z, dmag_y, dmag_x};
    node.h  = {field_z, field_y, field_x};
    node.hp = {dfield_z, dfield_y, dfield_x};
    coeff.damping    = damping_coeff;
    coeff.precession = precession_coeff;
    coeff.relaxation = relaxation_coeff;
    coeff.enable     = term_enable;
  end

  llgjv_dot u_dot (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (accept),
    .node      (node),
    .out_valid (dot_valid),
    .dot       (dot)
  );

  llgjv_bracket u_bracket (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (dot_valid),
    .dot       (dot),
    .out_valid (br_valid),
    .br        (br)
  );

  llgjv_scale u_scale (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (br_valid),
    .br        (br),
    .coeff     (coeff),
    .out_valid (done),
    .contrib   (contrib),
    .saturated (saturated)
  );

  assign contrib_x = contrib[0];
  assign contrib_y = contrib[1];
  assign contrib_z = contrib[2];

endmodule

>>> rtl/llgjv_dot.sv
module llgjv_dot (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  llgjv_pkg::node_t  node,
  output logic              out_valid,
  output llgjv_pkg::dot_t   dot
);

  localparam int WordW = llgjv_pkg::WordW;
  localparam int FracM = llgjv_pkg::FracM;
  localparam int ProdW = llgjv_pkg::ProdW;
  localparam int DotW  = llgjv_pkg::DotW;
  localparam int PrecW = llgjv_pkg::PrecW;
  localparam int Nxt [3] = '{1, 2, 0};
  localparam int Prv [3] = '{2, 0, 1};
  localparam logic signed [DotW-1:0] OneQ = DotW'(64'sd1 <<< FracM);

  function automatic logic signed [ProdW-1:0] mul_floor(input llgjv_pkg::word_t a,
                                                        input llgjv_pkg::word_t b);
    logic signed [2*WordW-1:0] p;
    p = (2*WordW)'(a) * (2*WordW)'(b);
    return p[2*WordW-1:FracM];
  endfunction

  // stage a: products
  logic              a_valid;
  llgjv_pkg::node_t  a_node;
  logic signed [ProdW-1:0] p_mh  [3];
  logic signed [ProdW-1:0] p_mph [3];
  logic signed [ProdW-1:0] p_mhp [3];
  logic signed [ProdW-1:0] p_mm  [3];
  logic signed [ProdW-1:0] p_mmp [3];
  logic signed [ProdW-1:0] x_a   [3];
  logic signed [ProdW-1:0] x_b   [3];
  logic signed [ProdW-1:0] x_c   [3];
  logic signed [ProdW-1:0] x_d   [3];

  // stage b sums
  logic signed [DotW-1:0]  mh_sum;
  logic signed [DotW-1:0]  mphh_sum;
  logic signed [DotW-1:0]  mm_sum;
  logic signed [DotW-1:0]  mmp_sum;
  llgjv_pkg::prec3_t       prec_sum;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      a_valid   <= in_valid;
      out_valid <= a_valid;
    end
  end

  always_ff @(posedge clk) begin
    a_node <= node;
    for (int i = 0; i < 3; i++) begin
      p_mh[i]  <= mul_floor(node.m[i], node.h[i]);
      p_mph[i] <= mul_floor(node.mp[i], node.h[i]);
      p_mhp[i] <= mul_floor(node.m[i], node.hp[i]);
      p_mm[i]  <= mul_floor(node.m[i], node.m[i]);
      p_mmp[i] <= mul_floor(node.m[i], node.mp[i]);
      x_a[i]   <= mul_floor(node.mp[Nxt[i]], node.h[Prv[i]]);
      x_b[i]   <= mul_floor(node.mp[Prv[i]], node.h[Nxt[i]]);
      x_c[i]   <= mul_floor(node.m[Nxt[i]], node.hp[Prv[i]]);
      x_d[i]   <= mul_floor(node.m[Prv[i]], node.hp[Nxt[i]]);
    end
  end

  always_comb begin
    mh_sum   = DotW'(p_mh[0]) + DotW'(p_mh[1]) + DotW'(p_mh[2]);
    mphh_sum = DotW'(p_mph[0]) + DotW'(p_mph[1]) + DotW'(p_mph[2])
             + DotW'(p_mhp[0]) + DotW'(p_mhp[1]) + DotW'(p_mhp[2]);
    mm_sum   = DotW'(p_mm[0]) + DotW'(p_mm[1]) + DotW'(p_mm[2]);
    mmp_sum  = DotW'(p_mmp[0]) + DotW'(p_mmp[1]) + DotW'(p_mmp[2]);
    for (int i = 0; i < 3; i++) begin
      prec_sum[i] = PrecW'(x_a[i]) - PrecW'(x_b[i]) + PrecW'(x_c[i]) - PrecW'(x_d[i]);
    end
  end

  // stage b: dot products and precession brackets
  always_ff @(posedge clk) begin
    dot.node   <= a_node;
    dot.mh     <= mh_sum;
    dot.mphh   <= mphh_sum;
    dot.mm     <= mm_sum;
    dot.mmp    <= mmp_sum;
    dot.one_mm <= OneQ - mm_sum;
    dot.prec   <= prec_sum;
  end

endmodule

>>> rtl/llgjv_bracket.sv
module llgjv_bracket (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  llgjv_pkg::dot_t      dot,
  output logic                 out_valid,
  output llgjv_pkg::bracket_t  br
);

  localparam int WordW = llgjv_pkg::WordW;
  localparam int DotW  = llgjv_pkg::DotW;
  localparam int BrW   = llgjv_pkg::BrW;
  localparam int FracM = llgjv_pkg::FracM;
  localparam int MulW  = WordW + DotW;

  function automatic llgjv_pkg::br_t mul_shift(input llgjv_pkg::word_t a,
                                              input llgjv_pkg::dot_val_t b,
                                              input int unsigned s);
    logic signed [MulW-1:0] p;
    p = MulW'(a) * MulW'(b);
    return BrW'(p >>> s);
  endfunction

  // stage c: products against the dot products
  logic               c_valid;
  llgjv_pkg::br_t     t_d1 [3];
  llgjv_pkg::br_t     t_d2 [3];
  llgjv_pkg::br_t     t_d3 [3];
  llgjv_pkg::br_t     t_d4 [3];
  llgjv_pkg::br_t     t_r1 [3];
  llgjv_pkg::br_t     t_r2 [3];
  llgjv_pkg::prec3_t  c_prec;

  always_ff @(posedge clk) begin
    if (rst) begin
      c_valid   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      c_valid   <= in_valid;
      out_valid <= c_valid;
    end
  end

  always_ff @(posedge clk) begin
    c_prec <= dot.prec;
    for (int i = 0; i < 3; i++) begin
      t_d1[i] <= mul_shift(dot.node.mp[i], dot.mh, FracM);
      t_d2[i] <= mul_shift(dot.node.m[i], dot.mphh, FracM);
      t_d3[i] <= mul_shift(dot.node.hp[i], dot.mm, FracM);
      t_d4[i] <= mul_shift(dot.node.h[i], dot.mmp, FracM - 1);
      t_r1[i] <= mul_shift(dot.node.m[i], dot.mmp, FracM - 1);
      t_r2[i] <= mul_shift(dot.node.mp[i], dot.one_mm, FracM);
    end
  end

  // stage d: bracket sums
  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      br.damp[i]  <= t_d1[i] + t_d2[i] - t_d3[i] - t_d4[i];
      br.relax[i] <= t_r2[i] - t_r1[i];
      br.prec[i]  <= BrW'(c_prec[i]);
    end
  end

endmodule

>>> rtl/llgjv_scale.sv
module llgjv_scale (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  llgjv_pkg::bracket_t  br,
  input  llgjv_pkg::coeff_t    coeff,
  output logic                 out_valid,
  output llgjv_pkg::out3_t     contrib,
  output logic                 saturated
);

  localparam int WordW  = llgjv_pkg::WordW;
  localparam int BrW    = llgjv_pkg::BrW;
  localparam int SplitW = llgjv_pkg::SplitW;
  localparam int TermW  = llgjv_pkg::TermW;
  localparam int SumW   = llgjv_pkg::SumW;
  localparam int OutW   = llgjv_pkg::OutW;
  localparam int HiW    = WordW + BrW - SplitW;
  localparam int LoW    = WordW + SplitW + 1;
  localparam int FullW  = WordW + BrW + 1;
  localparam logic signed [SumW-1:0] SatMax = SumW'((64'sd1 <<< (OutW - 1)) - 64'sd1);
  localparam logic signed [SumW-1:0] SatMin = SumW'(-(64'sd1 <<< (OutW - 1)));

  function automatic logic signed [HiW-1:0] hi_mul(input llgjv_pkg::word_t c,
                                                   input llgjv_pkg::br_t b);
    return HiW'(c) * HiW'($signed(b[BrW-1:SplitW]));
  endfunction

  function automatic logic signed [LoW-1:0] lo_mul(input llgjv_pkg::word_t c,
                                                   input llgjv_pkg::br_t b);
    return LoW'(c) * LoW'($signed({1'b0, b[SplitW-1:0]}));
  endfunction

  function automatic logic signed [TermW-1:0] join_shift(input logic signed [HiW-1:0] hi,
                                                         input logic signed [LoW-1:0] lo,
                                                         input int unsigned s);
    logic signed [FullW-1:0] f;
    f = (FullW'(hi) <<< SplitW) + FullW'(lo);
    return TermW'(f >>> s);
  endfunction

  // stage e: coefficient products, bracket split in two halves
  logic                    e_valid;
  logic signed [HiW-1:0]   hi_d [3];
  logic signed [LoW-1:0]   lo_d [3];
  logic signed [HiW-1:0]   hi_p [3];
  logic signed [LoW-1:0]   lo_p [3];
  logic signed [HiW-1:0]   hi_r [3];
  logic signed [LoW-1:0]   lo_r [3];

  // stage f: enabled terms
  logic                    f_valid;
  logic signed [TermW-1:0] term_d [3];
  logic signed [TermW-1:0] term_p [3];
  logic signed [TermW-1:0] term_r [3];

  // stage g
  logic signed [SumW-1:0]  total [3];
  logic [2:0]              clip;
  llgjv_pkg::out3_t        clipped;

  always_ff @(posedge clk) begin
    if (rst) begin
      e_valid   <= 1'b0;
      f_valid   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      e_valid   <= in_valid;
      f_valid   <= e_valid;
      out_valid <= f_valid;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      hi_d[i] <= hi_mul(coeff.damping, br.damp[i]);
      lo_d[i] <= lo_mul(coeff.damping, br.damp[i]);
      hi_p[i] <= hi_mul(coeff.precession, br.prec[i]);
      lo_p[i] <= lo_mul(coeff.precession, br.prec[i]);
      hi_r[i] <= hi_mul(coeff.relaxation, br.relax[i]);
      lo_r[i] <= lo_mul(coeff.relaxation, br.relax[i]);
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      term_d[i] <= coeff.enable[llgjv_pkg::EnDamping]
                 ? join_shift(hi_d[i], lo_d[i], llgjv_pkg::CoeffShift) : '0;
      term_p[i] <= coeff.enable[llgjv_pkg::EnPrecession]
                 ? join_shift(hi_p[i], lo_p[i], llgjv_pkg::CoeffShift) : '0;
      term_r[i] <= coeff.enable[llgjv_pkg::EnRelaxation]
                 ? join_shift(hi_r[i], lo_r[i], llgjv_pkg::RelaxShift) : '0;
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      total[i] = SumW'(term_d[i]) + SumW'(term_p[i]) + SumW'(term_r[i]);
      if (total[i] > SatMax) begin
        clip[i]    = 1'b1;
        clipped[i] = OutW'(SatMax);
      end else if (total[i] < SatMin) begin
        clip[i]    = 1'b1;
        clipped[i] = OutW'(SatMin);
      end else begin
        clip[i]    = 1'b0;
        clipped[i] = OutW'(total[i]);
      end
    end
  end

  always_ff @(posedge clk) begin
    contrib   <= clipped;
    saturated <= |clip;
  end

endmodule

>>> rtl/llgjv_checker.sv
`include "llg_jacobian_vector_product_unit_assert.svh"

module llgjv_checker (
  input logic        clk,
  input logic        rst,
  input logic        start,
  input logic        busy,
  input logic        done,
  input logic [47:0] contrib_x,
  input logic [47:0] contrib_y,
  input logic [47:0] contrib_z,
  input logic        saturated
);

  localparam int Lat = llgjv_pkg::Latency;
  localparam logic [47:0] OutMax = {1'b0, {47{1'b1}}};
  localparam logic [47:0] OutMin = {1'b1, {47{1'b0}}};

  logic xfer_in;
  logic at_limit;

  assign xfer_in  = start && !busy;
  assign at_limit = contrib_x == OutMax || contrib_x == OutMin
                 || contrib_y == OutMax || contrib_y == OutMin
                 || contrib_z == OutMax || contrib_z == OutMin;

  // every input transfer gives a result after the pipeline latency
  `LLGJV_ASSERT_DLY(a_result_follows, clk, rst, xfer_in, Lat, done)
  // no result without a matching input transfer
  `LLGJV_ASSERT_IMP(a_no_spurious, clk, rst, done, $past(xfer_in, Lat))
  // a clipped result sits on a range limit
  `LLGJV_ASSERT_IMP(a_sat_limit, clk, rst, done && saturated, at_limit)
  // reset flushes the pipeline
  `LLGJV_ASSERT_ALL(a_reset_flush, clk, $past(rst) && !rst, !done)

endmodule

bind llg_jacobian_vector_product_unit llgjv_checker u_llgjv_checker (
  .clk       (clk),
  .rst       (rst),
  .start     (start),
  .busy      (busy),
  .done      (done),
  .contrib_x (contrib_x),
  .contrib_y (contrib_y),
  .contrib_z (contrib_z),
  .saturated (saturated)
);

>>> test/llg_jacobian_vector_product_checker.sv
module llg_jacobian_vector_product_checker
  import llgjv_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic        busy,
  input  node_t       node,
  input  logic        cfg_write,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data,
  input  logic        done,
  input  logic [47:0] contrib_x,
  input  logic [47:0] contrib_y,
  input  logic [47:0] contrib_z,
  input  logic        saturated,
  output int          fail_count,
  output int          outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    out3_t value;
    logic  sat;
  } contrib_t;

  localparam longint ContribMax = (longint'(1) << (OutW - 1)) - 1;
  localparam longint ContribMin = -(longint'(1) << (OutW - 1));
  localparam longint OneQ29     = longint'(1) << FracM;

  coeff_t   coeffs;
  contrib_t pending_contrib[$];
  contrib_t want;
  out3_t    got;
  int       mismatches = 0;
  string    axis_name[3] = '{"contrib_x", "contrib_y", "contrib_z"};

  assign got = {contrib_z, contrib_y, contrib_x};
  assign fail_count = mismatches;

  // floor(a*b / 2^sh) on the exact product
  function automatic longint floor_mul_shift(longint a, longint b, int unsigned sh);
    logic signed [127:0] wide_a, wide_b, prod;
    wide_a = a;
    wide_b = b;
    prod = (wide_a * wide_b) >>> sh;
    return prod[63:0];
  endfunction

  function automatic contrib_t predict_contribution(node_t n, coeff_t c);
    longint   m[3], mp[3], h[3], hp[3];
    longint   mh, mphh, mm, mmp, bracket, total;
    int       j, k;
    contrib_t res;
    mh = 0;
    mphh = 0;
    mm = 0;
    mmp = 0;
    res.sat = 1'b0;
    for (int i = 0; i < 3; i++) begin
      m[i]  = longint'(signed'(n.m[i]));
      mp[i] = longint'(signed'(n.mp[i]));
      h[i]  = longint'(signed'(n.h[i]));
      hp[i] = longint'(signed'(n.hp[i]));
    end
    for (int i = 0; i < 3; i++) begin
      mh   += floor_mul_shift(m[i], h[i], FracM);
      mphh += floor_mul_shift(mp[i], h[i], FracM) + floor_mul_shift(m[i], hp[i], FracM);
      mm   += floor_mul_shift(m[i], m[i], FracM);
      mmp  += floor_mul_shift(m[i], mp[i], FracM);
    end
    for (int i = 0; i < 3; i++) begin
      j = (i + 1) % 3;
      k = (i + 2) % 3;
      total = 0;
      if (c.enable[EnDamping]) begin
        bracket = floor_mul_shift(mp[i], mh, FracM) + floor_mul_shift(m[i], mphh, FracM)
                - floor_mul_shift(hp[i], mm, FracM) - floor_mul_shift(h[i], mmp, FracM - 1);
        total += floor_mul_shift(longint'(signed'(c.damping)), bracket, CoeffShift);
      end
      if (c.enable[EnPrecession]) begin
        bracket = floor_mul_shift(mp[j], h[k], FracM) - floor_mul_shift(mp[k], h[j], FracM)
                + floor_mul_shift(m[j], hp[k], FracM) - floor_mul_shift(m[k], hp[j], FracM);
        total += floor_mul_shift(longint'(signed'(c.precession)), bracket, CoeffShift);
      end
      if (c.enable[EnRelaxation]) begin
        bracket = -floor_mul_shift(mmp, m[i], FracM - 1)
                + floor_mul_shift(OneQ29 - mm, mp[i], FracM);
        total += floor_mul_shift(longint'(signed'(c.relaxation)), bracket, RelaxShift);
      end
      if (total > ContribMax) begin
        res.value[i] = out_t'(ContribMax);
        res.sat = 1'b1;
      end else if (total < ContribMin) begin
        res.value[i] = out_t'(ContribMin);
        res.sat = 1'b1;
      end else begin
        res.value[i] = out_t'(total);
      end
    end
    return res;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      coeffs.damping    <= '0;
      coeffs.precession <= '0;
      coeffs.relaxation <= '0;
      coeffs.enable     <= EnableReset;
      pending_contrib.delete();
      outstanding <= 0;
    end else begin
      if (cfg_write) begin
        case (reg_index_t'(cfg_index))
          RegDamping:    coeffs.damping    <= cfg_data;
          RegPrecession: coeffs.precession <= cfg_data;
          RegRelaxation: coeffs.relaxation <= cfg_data;
          RegTermEnable: coeffs.enable     <= cfg_data[EnW-1:0];
          default: ;
        endcase
      end
      if (start && !busy) begin
        pending_contrib.push_back(predict_contribution(node, coeffs));
      end
      if (done) begin
        if (pending_contrib.size() == 0) begin
          $error("result with no node pending: contrib_x %0d", signed'(contrib_x));
          mismatches++;
        end else begin
          want = pending_contrib.pop_front();
          for (int i = 0; i < 3; i++) begin
            if (got[i] !== want.value[i]) begin
              $error("%s: expected %0d, got %0d", axis_name[i], want.value[i], got[i]);
              mismatches++;
            end
          end
          if (saturated !== want.sat) begin
            $error("saturated: expected %0d, got %0d", want.sat, saturated);
            mismatches++;
          end
        end
      end
      outstanding <= pending_contrib.size();
    end
  end

endmodule

>>> test/tb_llg_jacobian_vector_product_unit.sv
module tb_llg_jacobian_vector_product_unit;
  timeunit 1ns;
  timeprecision 1ps;
  import llgjv_pkg::*;

  localparam int    IdleLimit  = 5000;
  localparam int    PhaseCount = 11;
  localparam int    PhaseItems = 150;
  localparam word_t WordMax    = 32'sh7fff_ffff;
  localparam word_t WordMin    = 32'sh8000_0000;
  localparam word_t CoeffOne   = 32'sh0080_0000;

  logic        clk;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        busy;
  node_t       stim = '0;
  logic        cfg_write = 1'b0;
  logic [1:0]  cfg_index = '0;
  logic [31:0] cfg_data = '0;
  logic        done;
  logic [47:0] contrib_x, contrib_y, contrib_z;
  logic        saturated;
  int          fail_count;
  int          outstanding;
  int          idle_cycles = 0;
  int unsigned idle_pcts[3] = '{0, 64, 24};

  llg_jacobian_vector_product_unit uut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .mag_x     (stim.m[0]),
    .mag_y     (stim.m[1]),
    .mag_z     (stim.m[2]),
    .dmag_x    (stim.mp[0]),
    .dmag_y    (stim.mp[1]),
    .dmag_z    (stim.mp[2]),
    .field_x   (stim.h[0]),
    .field_y   (stim.h[1]),
    .field_z   (stim.h[2]),
    .dfield_x  (stim.hp[0]),
    .dfield_y  (stim.hp[1]),
    .dfield_z  (stim.hp[2]),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .done      (done),
    .contrib_x (contrib_x),
    .contrib_y (contrib_y),
    .contrib_z (contrib_z),
    .saturated (saturated)
  );

  llg_jacobian_vector_product_checker chk (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .node        (stim),
    .cfg_write   (cfg_write),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .done        (done),
    .contrib_x   (contrib_x),
    .contrib_y   (contrib_y),
    .contrib_z   (contrib_z),
    .saturated   (saturated),
    .fail_count  (fail_count),
    .outstanding (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IdleLimit) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  // mix of extremes, full-range words and words arithmetic-shifted right by 1 to 24 bits
  function automatic word_t pick_word();
    int unsigned sel;
    word_t       w;
    sel = $urandom_range(0, 99);
    w = $urandom;
    if (sel < 15) begin
      case ($urandom_range(0, 4))
        0: w = WordMax;
        1: w = WordMin;
        2: w = '0;
        3: w = -1;
        default: w = 1;
      endcase
    end else if (sel >= 40) begin
      w = w >>> $urandom_range(1, 24);
    end
    return w;
  endfunction

  function automatic node_t random_node();
    node_t n;
    for (int i = 0; i < 3; i++) begin
      n.m[i]  = pick_word();
      n.mp[i] = pick_word();
      n.h[i]  = pick_word();
      n.hp[i] = pick_word();
    end
    return n;
  endfunction

  task automatic send_node(node_t n, int unsigned idle_pct);
    if ($urandom_range(0, 99) < idle_pct) begin
      repeat ($urandom_range(1, 3)) begin
        @(negedge clk);
        start <= 1'b0;
      end
    end
    @(negedge clk);
    start <= 1'b1;
    stim  <= n;
    do @(posedge clk); while (busy);
  endtask

  // wait until every result is back and the pipeline has drained
  task automatic settle();
    @(negedge clk);
    start <= 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (Latency + 2) @(negedge clk);
  endtask

  task automatic write_reg(reg_index_t idx, word_t val);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
    cfg_write <= 1'b0;
  endtask

  task automatic configure(word_t damp, word_t prec, word_t relax, logic [EnW-1:0] en);
    settle();
    write_reg(RegDamping, damp);
    write_reg(RegPrecession, prec);
    write_reg(RegRelaxation, relax);
    write_reg(RegTermEnable, 32'(en));
  endtask

  initial begin
    node_t          unit;
    node_t          alt;
    logic [EnW-1:0] en;
    unit = '0;
    unit.m[0]  = 32'sh2000_0000;
    unit.mp[1] = 32'sh2000_0000;
    unit.h[2]  = 32'sh0000_8000;
    unit.hp[0] = 32'sh0000_8000;
    alt = {6{WordMax, WordMin}};

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // reset coefficients are zero
    send_node(unit, 0);
    send_node({12{WordMax}}, 0);

    configure(CoeffOne, -CoeffOne, CoeffOne >>> 1, 3'b111);
    send_node('0, 0);
    send_node({12{WordMax}}, 0);
    send_node({12{WordMin}}, 0);
    send_node({12{32'hffff_ffff}}, 0);
    send_node({12{32'h0000_0001}}, 0);
    send_node(alt, 0);
    send_node(unit, 0);
    send_node({{3{WordMax}}, {3{WordMin}}, {3{WordMax}}, {3{WordMin}}}, 0);

    // each term alone, then none
    foreach (idle_pcts[i]) begin
      configure(CoeffOne, -CoeffOne, CoeffOne >>> 1, 3'b001 << i);
      send_node(unit, 0);
      send_node(alt, 0);
    end
    configure(CoeffOne, -CoeffOne, CoeffOne >>> 1, 3'b000);
    send_node(unit, 0);
    send_node(alt, 0);

    // full-scale coefficients drive the sums into saturation
    configure(WordMax, WordMin, WordMax, 3'b111);
    send_node({12{WordMax}}, 0);
    send_node({12{WordMin}}, 0);
    send_node(alt, 0);

    for (int p = 0; p < PhaseCount; p++) begin
      en = (p < 8) ? EnW'((p + 7) % 8) : EnW'($urandom_range(0, 7));
      case (p)
        0: configure(WordMax, WordMax, WordMax, en);
        1: configure(WordMin, WordMin, WordMin, en);
        default: configure(pick_word(), pick_word(), pick_word(), en);
      endcase
      repeat (PhaseItems) send_node(random_node(), idle_pcts[p % 3]);
    end

    settle();
    if (outstanding != 0) begin
      $error("%0d expected results never arrived", outstanding);
    end
    if (fail_count == 0 && outstanding == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
